// ===== src/rrm_pkg.sv =====
package rrm_pkg;

	// One input word: the rotation vector, signed Q8.24 radians.
	typedef struct packed {
		logic signed [31:0] theta_x;
		logic signed [31:0] theta_y;
		logic signed [31:0] theta_z;
	} theta_t;

	// One output word: the rotation matrix, row major, signed Q1.30.
	typedef struct packed {
		logic signed [31:0] r00;
		logic signed [31:0] r01;
		logic signed [31:0] r02;
		logic signed [31:0] r10;
		logic signed [31:0] r11;
		logic signed [31:0] r12;
		logic signed [31:0] r20;
		logic signed [31:0] r21;
		logic signed [31:0] r22;
	} rot_t;

	localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
	localparam logic [31:0] MINUS_ONE_Q30 = 32'hC000_0000;
	localparam logic [63:0] HALF_PI_Q56 = 64'h0192_1FB5_4442_D184;

	// Series lanes of the sine/cosine evaluator.
	localparam int LANE_SIN = 0;
	localparam int LANE_COS = 1;

	// Horner divisors of the sine and cosine series, innermost term first.
	function automatic logic [7:0] horner_div(logic is_cos, int k);
		logic [7:0] d;
		d = 8'd1;
		if (!is_cos) begin
			case (k)
				0: d = 8'd210;
				1: d = 8'd156;
				2: d = 8'd110;
				3: d = 8'd72;
				4: d = 8'd42;
				5: d = 8'd20;
				6: d = 8'd6;
				default: d = 8'd1;
			endcase
		end else begin
			case (k)
				0: d = 8'd240;
				1: d = 8'd182;
				2: d = 8'd132;
				3: d = 8'd90;
				4: d = 8'd56;
				5: d = 8'd30;
				6: d = 8'd12;
				default: d = 8'd1;
			endcase
		end
		return d;
	endfunction

	// floor(2^32 / divisor) for the divisors above.
	function automatic logic [29:0] horner_recip(logic is_cos, int k);
		logic [29:0] m;
		m = 30'd0;
		if (!is_cos) begin
			case (k)
				0: m = 30'd20452225;
				1: m = 30'd27531841;
				2: m = 30'd39045157;
				3: m = 30'd59652323;
				4: m = 30'd102261126;
				5: m = 30'd214748364;
				6: m = 30'd715827882;
				default: m = 30'd0;
			endcase
		end else begin
			case (k)
				0: m = 30'd17895697;
				1: m = 30'd23598721;
				2: m = 30'd32537631;
				3: m = 30'd47721858;
				4: m = 30'd76695844;
				5: m = 30'd143165576;
				6: m = 30'd357913941;
				default: m = 30'd0;
			endcase
		end
		return m;
	endfunction

	// Q30 by Q30 product, rounded to nearest on the magnitude, ties away from zero.
	function automatic logic signed [33:0] mul30(logic signed [33:0] a, logic signed [33:0] b);
		logic [33:0] ma;
		logic [33:0] mb;
		logic [67:0] pr;
		logic [33:0] m;
		ma = a[33] ? 34'(-a) : 34'(a);
		mb = b[33] ? 34'(-b) : 34'(b);
		pr = 68'(ma) * 68'(mb) + (68'd1 << 29);
		m = pr[63:30];
		return (a[33] ^ b[33]) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [31:0] clamp_q30(logic signed [34:0] v);
		logic [31:0] r;
		if (v > 35'sd1073741824) begin
			r = ONE_Q30;
		end else if (v < -35'sd1073741824) begin
			r = MINUS_ONE_Q30;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic in_unit(logic [31:0] v);
		return ($signed(v) <= 32'sd1073741824) && ($signed(v) >= -32'sd1073741824);
	endfunction

endpackage

// ===== src/rrm_dly.sv =====
module rrm_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] d_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= din;
			for (int i = 1; i < N; i++) begin
				d_s[i] <= d_s[i-1];
			end
		end
	end

	assign dout = d_s[N-1];

endmodule

// ===== src/rrm_isqrt.sv =====
module rrm_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] s,
	output logic [31:0] root
);

	// Two result bits per stage, sixteen stages.
	localparam int STEPS  = 2;
	localparam int STAGES = 32 / STEPS;

	logic [63:0] rad_s  [STAGES+1];
	logic [33:0] rem_s  [STAGES+1];
	logic [31:0] root_s [STAGES+1];

	assign rad_s[0]  = s;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [63:0] rad_n;
		logic [33:0] rem_n;
		logic [31:0] root_n;

		always_comb begin : step
			logic [35:0] r;
			logic [33:0] trial;
			logic [31:0] q;
			logic [63:0] b;
			r = {2'b00, rem_s[g]};
			q = root_s[g];
			b = rad_s[g];
			for (int j = 0; j < STEPS; j++) begin
				r = {r[33:0], b[63:62]};
				trial = {q, 2'b01};
				if (r >= {2'b00, trial}) begin
					r = r - {2'b00, trial};
					q = {q[30:0], 1'b1};
				end else begin
					q = {q[30:0], 1'b0};
				end
				b = {b[61:0], 2'b00};
			end
			rad_n  = b;
			rem_n  = r[33:0];
			root_n = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= rad_n;
				rem_s[g+1]  <= rem_n;
				root_s[g+1] <= root_n;
			end
		end
	end

	assign root = root_s[STAGES];

endmodule

// ===== src/rrm_udiv.sv =====
module rrm_udiv (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] mag,
	input  logic [31:0] den,
	output logic [30:0] quo
);

	// Computes (mag << 30) / den for mag <= den, two quotient bits per stage.
	localparam int STEPS  = 2;
	localparam int STAGES = 32 / STEPS;

	logic [31:0] rem_s [STAGES+1];
	logic [31:0] num_s [STAGES+1];
	logic [31:0] quo_s [STAGES+1];
	logic [31:0] den_s [STAGES+1];

	assign rem_s[0] = {2'b00, mag[31:2]};
	assign num_s[0] = {mag[1:0], 30'd0};
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [31:0] rem_n;
		logic [31:0] num_n;
		logic [31:0] quo_n;

		always_comb begin : step
			logic [32:0] r;
			logic [31:0] nb;
			logic [31:0] q;
			r = {1'b0, rem_s[g]};
			nb = num_s[g];
			q = quo_s[g];
			for (int j = 0; j < STEPS; j++) begin
				r = {r[31:0], nb[31]};
				if (r >= {1'b0, den_s[g]}) begin
					r = r - {1'b0, den_s[g]};
					q = {q[30:0], 1'b1};
				end else begin
					q = {q[30:0], 1'b0};
				end
				nb = {nb[30:0], 1'b0};
			end
			rem_n = r[31:0];
			num_n = nb;
			quo_n = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_n;
				num_s[g+1] <= num_n;
				quo_s[g+1] <= quo_n;
				den_s[g+1] <= den_s[g];
			end
		end
	end

	assign quo = quo_s[STAGES][30:0];

endmodule

// ===== src/rrm_trig.sv =====
module rrm_trig (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        a,
	output logic signed [32:0] sn,
	output logic signed [32:0] cs,
	output logic signed [33:0] omc
);

	localparam int RED_STAGES = 4;
	localparam int HSTEPS     = 7;
	localparam int HSTAGES    = 3 * HSTEPS;
	localparam logic [30:0] ONE31 = 31'h4000_0000;
	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	// Angle reduction: restoring division of (a << 32) by pi/2 in Q56.
	// Only the two low quotient bits (the quadrant) and the remainder are kept.
	logic [63:0] red_rem_s [RED_STAGES+1];
	logic [1:0]  red_q_s   [RED_STAGES+1];

	assign red_rem_s[0] = {a, 32'd0};
	assign red_q_s[0]   = '0;

	for (genvar g = 0; g < RED_STAGES; g++) begin : g_red
		logic [63:0] rem_n;
		logic [1:0]  q_n;

		always_comb begin : step
			logic [63:0] r;
			logic [63:0] hs;
			logic [1:0]  q;
			logic [2:0]  sh;
			r = red_rem_s[g];
			q = red_q_s[g];
			for (int j = 0; j < 2; j++) begin
				sh = 3'(7 - 2 * g - j);
				hs = rrm_pkg::HALF_PI_Q56 << sh;
				if (r >= hs) begin
					r = r - hs;
					q = {q[0], 1'b1};
				end else begin
					q = {q[0], 1'b0};
				end
			end
			rem_n = r;
			q_n = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				red_rem_s[g+1] <= rem_n;
				red_q_s[g+1]   <= q_n;
			end
		end
	end

	// Square of the reduced angle, then the side data rides alongside the series.
	logic [30:0] x_red;
	logic [61:0] x_sq;
	logic [30:0] xh_s  [HSTAGES+1];
	logic [31:0] x2h_s [HSTAGES+1];
	logic [1:0]  qh_s  [HSTAGES+1];

	assign x_red = red_rem_s[RED_STAGES][56:26];
	assign x_sq  = 62'(x_red) * 62'(x_red);

	always_ff @(posedge clk) begin
		if (en) begin
			xh_s[0]  <= x_red;
			x2h_s[0] <= x_sq[61:30];
			qh_s[0]  <= red_q_s[RED_STAGES];
			for (int h = 1; h <= HSTAGES; h++) begin
				xh_s[h]  <= xh_s[h-1];
				x2h_s[h] <= x2h_s[h-1];
				qh_s[h]  <= qh_s[h-1];
			end
		end
	end

	// Horner steps: product, reciprocal multiply, one-step quotient correction.
	logic [31:0] pa_s [2][HSTEPS];
	logic [31:0] pb_s [2][HSTEPS];
	logic [29:0] q0_s [2][HSTEPS];
	logic [30:0] tc_s [2][HSTEPS];

	for (genvar k = 0; k < HSTEPS; k++) begin : g_step
		for (genvar l = 0; l < 2; l++) begin : g_lane
			localparam logic [7:0]  DIV = rrm_pkg::horner_div(l == rrm_pkg::LANE_COS, k);
			localparam logic [29:0] RCP = rrm_pkg::horner_recip(l == rrm_pkg::LANE_COS, k);
			logic [30:0] t_in;
			logic [62:0] prod_a;
			logic [61:0] prod_b;
			logic [37:0] prod_c;
			logic [37:0] diff;
			logic        fix;

			if (k == 0) begin : g_first
				assign t_in = ONE31;
			end else begin : g_next
				assign t_in = tc_s[l][k-1];
			end

			assign prod_a = 63'(x2h_s[3*k]) * 63'(t_in);
			assign prod_b = 62'(pa_s[l][k]) * 62'(RCP);
			assign prod_c = 38'(q0_s[l][k]) * 38'(DIV);
			assign diff   = 38'(pb_s[l][k]) - prod_c;
			assign fix    = diff >= 38'(DIV);

			always_ff @(posedge clk) begin
				if (en) begin
					pa_s[l][k] <= prod_a[61:30];
					pb_s[l][k] <= pa_s[l][k];
					q0_s[l][k] <= prod_b[61:32];
					tc_s[l][k] <= ONE31 - {1'b0, q0_s[l][k] + {29'd0, fix}};
				end
			end
		end
	end

	// Final series products.
	logic [61:0] sin_prod;
	logic [62:0] cos_prod;
	logic [31:0] ps_s45;
	logic [31:0] pm_s45;
	logic [1:0]  q_s45;

	assign sin_prod = 62'(xh_s[HSTAGES]) * 62'(tc_s[rrm_pkg::LANE_SIN][HSTEPS-1]);
	assign cos_prod = 63'(x2h_s[HSTAGES]) * 63'(tc_s[rrm_pkg::LANE_COS][HSTEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s45 <= sin_prod[61:30];
			pm_s45 <= cos_prod[61:30];
			q_s45  <= qh_s[HSTAGES];
		end
	end

	// Cosine floor at zero, then quadrant mapping.
	logic [30:0]        m_half;
	logic [30:0]        pc;
	logic signed [32:0] ps_w;
	logic signed [32:0] pc_w;
	logic signed [32:0] sn_n;
	logic signed [32:0] cs_n;

	assign m_half = pm_s45[31:1];
	assign pc     = (m_half >= ONE31) ? 31'd0 : ONE31 - m_half;
	assign ps_w   = $signed({1'b0, ps_s45});
	assign pc_w   = $signed({2'b00, pc});

	always_comb begin
		case (q_s45)
			QUAD_I: begin
				sn_n = ps_w;
				cs_n = pc_w;
			end
			QUAD_II: begin
				sn_n = pc_w;
				cs_n = -ps_w;
			end
			QUAD_III: begin
				sn_n = -ps_w;
				cs_n = -pc_w;
			end
			QUAD_IV: begin
				sn_n = -pc_w;
				cs_n = ps_w;
			end
			default: begin
				sn_n = ps_w;
				cs_n = pc_w;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn  <= sn_n;
			cs  <= cs_n;
			omc <= $signed({2'b00, rrm_pkg::ONE_Q30}) - 34'(cs_n);
		end
	end

endmodule

// ===== src/rrm_matrix.sv =====
module rrm_matrix (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] u_x,
	input  logic signed [31:0] u_y,
	input  logic signed [31:0] u_z,
	input  logic signed [32:0] sn,
	input  logic signed [32:0] cs,
	input  logic signed [33:0] omc,
	input  logic               zero,
	output rrm_pkg::rot_t      rot
);

	logic signed [33:0] ux;
	logic signed [33:0] uy;
	logic signed [33:0] uz;
	logic signed [33:0] sw;

	assign ux = 34'(u_x);
	assign uy = 34'(u_y);
	assign uz = 34'(u_z);
	assign sw = 34'(sn);

	// Axis outer products and sine-scaled axis.
	logic signed [33:0] uu_s1 [6];
	logic signed [33:0] su_s1 [3];
	logic signed [32:0] cs_s1;
	logic signed [33:0] omc_s1;
	logic               zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			uu_s1[0] <= rrm_pkg::mul30(ux, ux);
			uu_s1[1] <= rrm_pkg::mul30(uy, uy);
			uu_s1[2] <= rrm_pkg::mul30(uz, uz);
			uu_s1[3] <= rrm_pkg::mul30(ux, uy);
			uu_s1[4] <= rrm_pkg::mul30(ux, uz);
			uu_s1[5] <= rrm_pkg::mul30(uy, uz);
			su_s1[0] <= rrm_pkg::mul30(sw, ux);
			su_s1[1] <= rrm_pkg::mul30(sw, uy);
			su_s1[2] <= rrm_pkg::mul30(sw, uz);
			cs_s1    <= cs;
			omc_s1   <= omc;
			zero_s1  <= zero;
		end
	end

	// Scale by one minus cosine.
	logic signed [33:0] ouu_s2 [6];
	logic signed [33:0] su_s2  [3];
	logic signed [32:0] cs_s2;
	logic               zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				ouu_s2[i] <= rrm_pkg::mul30(omc_s1, uu_s1[i]);
			end
			for (int i = 0; i < 3; i++) begin
				su_s2[i] <= su_s1[i];
			end
			cs_s2   <= cs_s1;
			zero_s2 <= zero_s1;
		end
	end

	// Sums, clamp, and the identity override for a null rotation.
	logic signed [34:0] c35;
	logic signed [34:0] o35 [6];
	logic signed [34:0] s35 [3];
	rrm_pkg::rot_t      rot_n;

	always_comb begin
		c35 = 35'(cs_s2);
		for (int i = 0; i < 6; i++) begin
			o35[i] = 35'(ouu_s2[i]);
		end
		for (int i = 0; i < 3; i++) begin
			s35[i] = 35'(su_s2[i]);
		end
		if (zero_s2) begin
			rot_n = '0;
			rot_n.r00 = rrm_pkg::ONE_Q30;
			rot_n.r11 = rrm_pkg::ONE_Q30;
			rot_n.r22 = rrm_pkg::ONE_Q30;
		end else begin
			rot_n.r00 = rrm_pkg::clamp_q30(c35 + o35[0]);
			rot_n.r11 = rrm_pkg::clamp_q30(c35 + o35[1]);
			rot_n.r22 = rrm_pkg::clamp_q30(c35 + o35[2]);
			rot_n.r01 = rrm_pkg::clamp_q30(o35[3] - s35[2]);
			rot_n.r10 = rrm_pkg::clamp_q30(o35[3] + s35[2]);
			rot_n.r02 = rrm_pkg::clamp_q30(o35[4] + s35[1]);
			rot_n.r20 = rrm_pkg::clamp_q30(o35[4] - s35[1]);
			rot_n.r12 = rrm_pkg::clamp_q30(o35[5] - s35[0]);
			rot_n.r21 = rrm_pkg::clamp_q30(o35[5] + s35[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot <= rot_n;
		end
	end

endmodule

// ===== src/axis_angle_to_rotation_matrix_core.sv =====
// Converts an axis-angle rotation vector (three signed Q8.24 components, in radians)
// into its 3x3 rotation matrix by the Rodrigues formula, R = cos(a) I + sin(a) [u]x +
// (1 - cos a) u u^T with a = |theta| and u = theta / a, each entry in signed Q1.30
// clamped to [-1, 1]. Angles of any size are reduced modulo 2*pi before sine and
// cosine, and a vector too short to give a nonzero norm returns the identity. The
// block is a 49-stage pipeline that takes one word per cycle unless the output stalls,
// and returns one word per input word, in order. The length is set by the square root
// (two result bits per stage, sixteen stages), the angle reduction (four stages), and
// the sine and cosine series, whose seven Horner steps each take three stages for a
// product, a reciprocal multiply and a quotient correction. The axis division runs
// beside the angle reduction and the series in sixteen stages. A stall on the output
// freezes the whole pipeline; nothing is dropped.
module axis_angle_to_rotation_matrix_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            theta_valid,
	output logic            theta_ready,
	input  rrm_pkg::theta_t theta,
	output logic            rot_valid,
	input  logic            rot_ready,
	output rrm_pkg::rot_t   rot
);

	localparam int LAT = 49;

	// The pipeline advances whenever the output register is empty or being taken.
	logic en;
	logic [LAT:1] v_s;

	assign en          = !v_s[LAT] || rot_ready;
	assign theta_ready = en;
	assign rot_valid   = v_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LAT-1:1], theta_valid};
		end
	end

	// Stage 1: component magnitudes and their squares.
	logic [31:0] mag_in [3];
	logic        neg_in [3];
	logic [31:0] mag_s1 [3];
	logic [63:0] sq_s1  [3];
	logic [2:0]  neg_s1;

	assign mag_in[0] = theta.theta_x[31] ? 32'(-theta.theta_x) : 32'(theta.theta_x);
	assign mag_in[1] = theta.theta_y[31] ? 32'(-theta.theta_y) : 32'(theta.theta_y);
	assign mag_in[2] = theta.theta_z[31] ? 32'(-theta.theta_z) : 32'(theta.theta_z);
	assign neg_in[0] = theta.theta_x[31];
	assign neg_in[1] = theta.theta_y[31];
	assign neg_in[2] = theta.theta_z[31];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_in[i];
				sq_s1[i]  <= 64'(mag_in[i]) * 64'(mag_in[i]);
				neg_s1[i] <= neg_in[i];
			end
		end
	end

	// Stage 2: squared norm, exact in 64 bits.
	logic [63:0] s_s2;
	logic [95:0] mag_s2;
	logic [2:0]  neg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2   <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			mag_s2 <= {mag_s1[0], mag_s1[1], mag_s1[2]};
			neg_s2 <= neg_s1;
		end
	end

	// Stages 3 to 18: integer square root gives the norm a in Q8.24.
	logic [31:0] norm;

	rrm_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.s    (s_s2),
		.root (norm)
	);

	logic [95:0] mag_d;
	logic [2:0]  neg_d;

	rrm_dly #(.W(96), .N(16)) u_mag_dly (
		.clk  (clk),
		.en   (en),
		.din  (mag_s2),
		.dout (mag_d)
	);

	rrm_dly #(.W(3), .N(32)) u_neg_dly (
		.clk  (clk),
		.en   (en),
		.din  (neg_s2),
		.dout (neg_d)
	);

	// Stages 19 to 34: unit axis, one divider per component.
	logic [30:0] quo [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		rrm_udiv u_udiv (
			.clk (clk),
			.en  (en),
			.mag (mag_d[95-32*i -: 32]),
			.den (norm),
			.quo (quo[i])
		);
	end

	// Signs go back on the axis, which then waits for the trig path.
	logic signed [31:0] u_sgn [3];
	logic [95:0]        u_pack;
	logic [95:0]        u_d;

	for (genvar i = 0; i < 3; i++) begin : g_sgn
		assign u_sgn[i] = neg_d[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
	end

	assign u_pack = {u_sgn[0], u_sgn[1], u_sgn[2]};

	rrm_dly #(.W(96), .N(12)) u_axis_dly (
		.clk  (clk),
		.en   (en),
		.din  (u_pack),
		.dout (u_d)
	);

	// A zero norm forces the identity at the output.
	logic zero_d;

	rrm_dly #(.W(1), .N(28)) u_zero_dly (
		.clk  (clk),
		.en   (en),
		.din  (norm == 32'd0),
		.dout (zero_d)
	);

	// Stages 19 to 46: angle reduction, sine and cosine, quadrant mapping.
	logic signed [32:0] sn;
	logic signed [32:0] cs;
	logic signed [33:0] omc;

	rrm_trig u_trig (
		.clk (clk),
		.en  (en),
		.a   (norm),
		.sn  (sn),
		.cs  (cs),
		.omc (omc)
	);

	// Stages 47 to 49: matrix assembly into the output register.
	rrm_matrix u_matrix (
		.clk  (clk),
		.en   (en),
		.u_x  ($signed(u_d[95:64])),
		.u_y  ($signed(u_d[63:32])),
		.u_z  ($signed(u_d[31:0])),
		.sn   (sn),
		.cs   (cs),
		.omc  (omc),
		.zero (zero_d),
		.rot  (rot)
	);

	// A held output must freeze every stage's valid bit.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_valid && !rot_ready) |=> $stable(v_s))
		else $error("pipeline advanced during an output stall");

	// Reset empties the pipeline.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> (v_s == '0))
		else $error("valid bits set during reset");

	// Every delivered entry lies within the unit range.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rot_valid |-> (rrm_pkg::in_unit(rot.r00) && rrm_pkg::in_unit(rot.r01) &&
			rrm_pkg::in_unit(rot.r02) && rrm_pkg::in_unit(rot.r10) &&
			rrm_pkg::in_unit(rot.r11) && rrm_pkg::in_unit(rot.r12) &&
			rrm_pkg::in_unit(rot.r20) && rrm_pkg::in_unit(rot.r21) &&
			rrm_pkg::in_unit(rot.r22)))
		else $error("matrix entry outside the clamp range");

endmodule
